/* rtl/hce_pkg.sv */
// Shared types, constants and helper functions for the chunked encoder.
package hce_pkg;

    localparam int CHUNK_CAPACITY = 4096;
    localparam int CNT_W   = $clog2(CHUNK_CAPACITY + 1);
    localparam int ADDR_W  = (CHUNK_CAPACITY > 1) ? $clog2(CHUNK_CAPACITY) : 1;
    localparam int NIB_N   = (CNT_W + 3) / 4;
    localparam int HL_W    = $clog2(NIB_N + 1);
    localparam int IDX_W   = $clog2(CHUNK_CAPACITY + NIB_N + 10);
    localparam int LIMIT_W = 13;
    localparam int EW      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_FINISH = 2'd1,
        OP_PULL   = 2'd2,
        OP_NOP    = 2'd3
    } hce_op_t;

    typedef enum logic [1:0] {
        PH_FILLING  = 2'd0,
        PH_DRAINING = 2'd1,
        PH_DONE     = 2'd2
    } hce_phase_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } hce_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       frame_end;
        logic       accepted;
        logic       stream_done;
    } hce_out_t;

    // Result computed at accept time; mem_sel swaps in the store read data.
    typedef struct packed {
        hce_out_t res;
        logic     mem_sel;
    } hce_stage_t;

    // Number of hex digits of v, without leading zeros (at least one).
    function automatic logic [HL_W-1:0] hex_len(input logic [CNT_W-1:0] v);
        logic [HL_W-1:0] n;
        n = HL_W'(1);
        for (int k = 1; k < NIB_N; k++) begin
            if ((v >> (4 * k)) != '0) begin
                n = HL_W'(k + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [CNT_W-1:0] v,
                                             input logic [HL_W-1:0] idx);
        logic [CNT_W+3:0] w;
        w = {4'b0000, v} >> {idx, 2'b00};
        return w[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (8'h30 + {4'b0000, d}) : (8'h57 + {4'b0000, d});
    endfunction

    // Trailer: CR LF, then "0" CR LF CR LF on a non-empty last chunk of a stream.
    function automatic logic [7:0] footer_byte(input logic [2:0] j);
        logic [7:0] b;
        case (j)
            3'd0:    b = CHAR_CR;
            3'd1:    b = CHAR_LF;
            3'd2:    b = CHAR_ZERO;
            3'd3:    b = CHAR_CR;
            3'd4:    b = CHAR_LF;
            3'd5:    b = CHAR_CR;
            default: b = CHAR_LF;
        endcase
        return b;
    endfunction

endpackage

/* rtl/hce_ram.sv */
// Generic single-port RAM with registered read.
module hce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                             wdata,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/hce_ctrl.sv */
// Encoder state and per-item framing logic; drives the chunk store port.
module hce_ctrl import hce_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  hce_in_t             in_item,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    output logic                ram_we,
    output logic                ram_re,
    output logic [ADDR_W-1:0]   ram_addr,
    output logic [7:0]          ram_wdata,
    output hce_stage_t          stage
);

    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   emit_reg, emit_next;
    hce_phase_t         phase_reg, phase_next;
    logic               final_reg, final_next;
    logic [LIMIT_W-1:0] limit_reg;

    logic [EW-1:0]      eff_limit;
    logic [CNT_W-1:0]   fill_inc;
    logic [HL_W-1:0]    hl;
    logic [IDX_W-1:0]   data_start;
    logic [IDX_W-1:0]   foot_start;
    logic [IDX_W-1:0]   total;
    logic [IDX_W-1:0]   mem_off;
    logic [IDX_W-1:0]   foot_off;
    logic [HL_W-1:0]    nib_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            emit_reg  <= '0;
            phase_reg <= PH_FILLING;
            final_reg <= 1'b0;
            limit_reg <= LIMIT_RESET;
        end else begin
            fill_reg  <= fill_next;
            emit_reg  <= emit_next;
            phase_reg <= phase_next;
            final_reg <= final_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        if (limit_reg == '0) begin
            eff_limit = EW'(1);
        end else if (EW'(limit_reg) > EW'(CHUNK_CAPACITY)) begin
            eff_limit = EW'(CHUNK_CAPACITY);
        end else begin
            eff_limit = EW'(limit_reg);
        end
    end

    assign fill_inc   = fill_reg + CNT_W'(1);
    assign hl         = hex_len(fill_reg);
    assign data_start = IDX_W'(hl) + IDX_W'(2);
    assign foot_start = data_start + IDX_W'(fill_reg);
    assign total      = foot_start +
                        (((final_reg) && (fill_reg != '0)) ? IDX_W'(7) : IDX_W'(2));
    assign mem_off    = emit_reg - data_start;
    assign foot_off   = emit_reg - foot_start;
    assign nib_idx    = hl - HL_W'(1) - emit_reg[HL_W-1:0];

    always_comb begin
        fill_next  = fill_reg;
        emit_next  = emit_reg;
        phase_next = phase_reg;
        final_next = final_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = fill_reg[ADDR_W-1:0];
        ram_wdata  = in_item.data_byte;
        stage      = '0;

        if (accept) begin
            case (hce_op_t'(in_item.opcode))
                OP_PUSH: begin
                    if (phase_reg == PH_FILLING && fill_reg < CNT_W'(CHUNK_CAPACITY)) begin
                        ram_we             = 1'b1;
                        fill_next          = fill_inc;
                        stage.res.accepted = 1'b1;
                        if (EW'(fill_inc) >= eff_limit) begin
                            phase_next = PH_DRAINING;
                            emit_next  = '0;
                        end
                    end
                end
                OP_FINISH: begin
                    if (phase_reg == PH_FILLING) begin
                        final_next         = 1'b1;
                        phase_next         = PH_DRAINING;
                        emit_next          = '0;
                        stage.res.accepted = 1'b1;
                    end
                end
                OP_PULL: begin
                    if (phase_reg == PH_DRAINING) begin
                        stage.res.out_valid = 1'b1;
                        if (emit_reg < IDX_W'(hl)) begin
                            stage.res.out_byte = hex_char(nibble_of(fill_reg, nib_idx));
                        end else if (emit_reg < data_start) begin
                            stage.res.out_byte = (emit_reg == IDX_W'(hl)) ? CHAR_CR : CHAR_LF;
                        end else if (emit_reg < foot_start) begin
                            // Payload byte comes back from the store's read register in the next cycle.
                            ram_re        = 1'b1;
                            ram_addr      = mem_off[ADDR_W-1:0];
                            stage.mem_sel = 1'b1;
                        end else begin
                            stage.res.out_byte = footer_byte(foot_off[2:0]);
                        end
                        if ((emit_reg + IDX_W'(1)) >= total) begin
                            stage.res.frame_end = 1'b1;
                            emit_next           = '0;
                            fill_next           = '0;
                            phase_next          = final_reg ? PH_DONE : PH_FILLING;
                        end else begin
                            emit_next = emit_reg + IDX_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
            stage.res.stream_done = (phase_next == PH_DONE);
        end
    end

endmodule

/* rtl/hce_outq.sv */
// Two-entry result path: store-read stage followed by the output register.
module hce_outq import hce_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  hce_stage_t stage,
    input  logic [7:0] ram_rdata,
    output logic       in_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output hce_out_t   m_data
);

    logic       s1_valid_reg;
    hce_stage_t s1_reg;
    logic       out_valid_reg;
    hce_out_t   out_reg;
    logic       out_free;
    logic       s1_adv;
    hce_out_t   s1_res;

    assign out_free = !out_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    always_comb begin
        s1_res = s1_reg.res;
        if (s1_reg.mem_sel) begin
            s1_res.out_byte = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= stage;
        end
        if (s1_adv) begin
            out_reg <= s1_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/http_chunked_encoder.sv */
// A result is held in the store-read stage, then in the output register that drives m_data.
// One item per cycle unless output stalls; the single store port serves one push or pull.
// A pull of a payload byte reads the store in the first stage; the second stage registers it.
// Reset (aresetn low, synchronous): empty store, filling phase, limit 4096, no result held.
// The store itself is not cleared; only bytes pushed since the last chunk are read back.
module http_chunked_encoder import hce_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hce_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output hce_out_t           m_data,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data
);

    logic              accept;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    hce_stage_t        stage;

    assign accept = s_valid && s_ready;

    hce_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_item     (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ram_we      (ram_we),
        .ram_re      (ram_re),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .stage       (stage)
    );

    hce_ram #(
        .WIDTH (8),
        .DEPTH (CHUNK_CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    hce_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .stage     (stage),
        .ram_rdata (ram_rdata),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* rtl/hce_checker.sv */
// Port-level checks for the chunked encoder, bound to the top level.
module hce_checker import hce_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input hce_out_t m_data
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    a_pull_not_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_valid |-> !m_data.accepted)
        else $error("item both emitted a byte and was taken as push or finish");

    a_end_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.out_valid)
        else $error("frame end without a byte");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_byte == 8'h00)
        else $error("byte set on a result without out_valid");

endmodule

bind http_chunked_encoder hce_checker u_hce_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/http_chunked_encoder_test.sv */
// Self-checking testbench for the HTTP chunked transfer encoder.
`timescale 1ns / 1ps

module http_chunked_encoder_test;
    import hce_pkg::*;

    // CR LF "0" CR LF CR LF, first byte in the top lane
    localparam logic [55:0] TRAILER = {CHAR_CR, CHAR_LF, CHAR_ZERO, CHAR_CR, CHAR_LF,
                                       CHAR_CR, CHAR_LF};

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    hce_in_t            s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    hce_out_t           m_data;
    logic               cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;

    // Encoder state as predicted from the accepted items
    logic [7:0]         chunk_bytes [CHUNK_CAPACITY];
    int unsigned        fill_n      = 0;
    int unsigned        emit_pos    = 0;
    bit                 final_seen  = 1'b0;
    hce_phase_t         enc_phase   = PH_FILLING;
    logic [LIMIT_W-1:0] limit_reg   = LIMIT_RESET;

    hce_out_t           chunk_results_q [$];
    hce_out_t           last_result;
    int                 mismatches    = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 stall_len     = 0;
    int                 stall_seq     = 0;
    int                 stall_seen    = 0;
    int                 recv_hold     = 0;

    http_chunked_encoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic hce_out_t chunk_encode_step(input hce_in_t item);
        hce_out_t    r;
        int unsigned lim, digits, body_at, tail_at, total, pos, nib, j;
        r = '0;
        case (hce_op_t'(item.opcode))
            OP_PUSH: begin
                if (enc_phase == PH_FILLING && fill_n < CHUNK_CAPACITY) begin
                    chunk_bytes[fill_n] = item.data_byte;
                    fill_n++;
                    r.accepted = 1'b1;
                    lim = (limit_reg == 0) ? 1 :
                          (limit_reg > CHUNK_CAPACITY) ? CHUNK_CAPACITY : limit_reg;
                    if (fill_n >= lim) begin
                        enc_phase = PH_DRAINING;
                        emit_pos  = 0;
                    end
                end
            end
            OP_FINISH: begin
                if (enc_phase == PH_FILLING) begin
                    final_seen = 1'b1;
                    enc_phase  = PH_DRAINING;
                    emit_pos   = 0;
                    r.accepted = 1'b1;
                end
            end
            OP_PULL: begin
                if (enc_phase == PH_DRAINING) begin
                    digits = 1;
                    while ((fill_n >> (4 * digits)) != 0) digits++;
                    body_at = digits + 2;
                    tail_at = body_at + fill_n;
                    total   = tail_at + ((final_seen && fill_n != 0) ? 7 : 2);
                    pos     = emit_pos;
                    if (pos < digits) begin
                        nib = (fill_n >> (4 * (digits - 1 - pos))) & 15;
                        r.out_byte = (nib < 10) ? 8'(48 + nib) : 8'(87 + nib);
                    end else if (pos == digits) begin
                        r.out_byte = CHAR_CR;
                    end else if (pos < body_at) begin
                        r.out_byte = CHAR_LF;
                    end else if (pos < tail_at) begin
                        r.out_byte = chunk_bytes[pos - body_at];
                    end else begin
                        j = pos - tail_at;
                        r.out_byte = TRAILER[55 - 8 * j -: 8];
                    end
                    r.out_valid = 1'b1;
                    if (pos + 1 >= total) begin
                        r.frame_end = 1'b1;
                        emit_pos    = 0;
                        fill_n      = 0;
                        enc_phase   = final_seen ? PH_DONE : PH_FILLING;
                    end else begin
                        emit_pos = pos + 1;
                    end
                end
            end
            default: ;
        endcase
        r.stream_done = (enc_phase == PH_DONE);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        hce_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (chunk_results_q.size() == 0) begin
                $error("unexpected item: out_byte %0h", m_data.out_byte);
                mismatches++;
            end else begin
                want = chunk_results_q.pop_front();
                check_field("out_byte", want.out_byte, m_data.out_byte);
                check_field("out_valid", 8'(want.out_valid), 8'(m_data.out_valid));
                check_field("frame_end", 8'(want.frame_end), 8'(m_data.frame_end));
                check_field("accepted", 8'(want.accepted), 8'(m_data.accepted));
                check_field("stream_done", 8'(want.stream_done), 8'(m_data.stream_done));
            end
        end
    end

    // Receiver: random stalls, plus a long hold whenever one is requested
    always @(negedge aclk) begin
        if (stall_seq != stall_seen) begin
            stall_seen = stall_seq;
            recv_hold  = stall_len;
        end
        if (recv_hold > 0) begin
            recv_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input hce_op_t op, input logic [7:0] b);
        hce_in_t item;
        int      gap;
        item.opcode    = op;
        item.data_byte = b;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        last_result = chunk_encode_step(item);
        chunk_results_q.push_back(last_result);
        @(negedge aclk);
    endtask

    task automatic push_bytes(input int n);
        repeat (n) send_item(OP_PUSH, 8'($urandom_range(0, 255)));
    endtask

    task automatic pull_chunk();
        while (enc_phase == PH_DRAINING) send_item(OP_PULL, 8'($urandom_range(0, 255)));
    endtask

    // Hold the input and wait until every expected result has come back
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (chunk_results_q.size() != 0);
    endtask

    task automatic write_chunk_limit(input logic [LIMIT_W-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        limit_reg = v;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Mostly well-formed traffic for the current phase, with some noise
    function automatic hce_op_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (enc_phase == PH_FILLING) begin
            if (r < 80) return OP_PUSH;
            if (r < 90) return OP_PULL;
            return OP_NOP;
        end
        if (r < 82) return OP_PULL;
        if (r < 90) return OP_PUSH;
        if (r < 95) return OP_FINISH;
        return OP_NOP;
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 13'd255;
            2:       return 13'd256;
            3:       return 13'd16;
            4:       return 13'($urandom_range(1, 300));
            default: return 13'($urandom_range(1, 24));
        endcase
    endfunction

    task automatic test_framing_basics();
        send_item(OP_PULL, 8'h00);
        send_item(OP_NOP, 8'hff);
        write_chunk_limit(13'd3);
        send_item(OP_PUSH, 8'h00);
        send_item(OP_PUSH, 8'hff);
        send_item(OP_PUSH, 8'ha5);
        // refused while draining
        send_item(OP_PUSH, 8'h11);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_NOP, 8'h5a);
        pull_chunk();
        send_item(OP_PULL, 8'h00);
    endtask

    task automatic test_limit_changes();
        pull_chunk();
        write_chunk_limit(13'd20);
        push_bytes(5);
        // limit now below the fill: the next push closes a longer chunk
        write_chunk_limit(13'd2);
        push_bytes(1);
        write_chunk_limit(13'd8191);
        pull_chunk();
        // oversized limit clamps to the store size; gather a three-digit chunk
        push_bytes(260);
        write_chunk_limit(13'd1);
        push_bytes(1);
        pull_chunk();
        write_chunk_limit(13'd0);
        push_bytes(1);
        pull_chunk();
        write_chunk_limit(13'd1);
        push_bytes(1);
        pull_chunk();
    endtask

    task automatic test_random_traffic(input int n_items);
        int counted;
        counted = 0;
        while (counted < n_items) begin
            if ($urandom_range(0, 99) == 0) write_chunk_limit(pick_limit());
            send_item(pick_op(), 8'($urandom_range(0, 255)));
            if (last_result.accepted || last_result.out_valid) counted++;
        end
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        write_chunk_limit(13'd12);
        stall_len = 300;
        stall_seq++;
        repeat (60) send_item(pick_op(), 8'($urandom_range(0, 255)));
        settle();
        repeat (40) send_item(pick_op(), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_stream_finish();
        pull_chunk();
        // close out any partial chunk so the store can start empty
        write_chunk_limit(13'd1);
        if (fill_n != 0) push_bytes(1);
        pull_chunk();
        write_chunk_limit(13'd50);
        if ($urandom_range(0, 1) == 1) push_bytes($urandom_range(1, 20));
        send_item(OP_FINISH, 8'h00);
        send_item(OP_PUSH, 8'h77);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_NOP, 8'h00);
        pull_chunk();
        send_item(OP_PULL, 8'h00);
        send_item(OP_PUSH, 8'h33);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_NOP, 8'hff);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_idling(10, 75);
        test_framing_basics();
        test_random_traffic(250);
        set_idling(75, 10);
        test_random_traffic(250);
        set_idling(0, 0);
        test_limit_changes();
        test_random_traffic(250);
        test_backpressure();
        test_stream_finish();
        settle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
rtl/hce_pkg.sv
rtl/hce_ram.sv
rtl/hce_ctrl.sv
rtl/hce_outq.sv
rtl/http_chunked_encoder.sv
rtl/hce_checker.sv
tb/http_chunked_encoder_test.sv
